// File: design/lcd_mwd_pkg.sv
// ----------------------------------------------------------------------------
// LCD multiplex waveform driver package
// Shared types, register indexes, the drive waveform table and small decoders.
// ----------------------------------------------------------------------------
package lcd_mwd_pkg;

  localparam int NUM_SEGMENTS_DEF = 24;
  localparam int SEG_W            = 24;
  localparam int NUM_COMMONS      = 4;
  localparam int IDX_W            = 4;
  localparam int VAL_W            = 8;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 24;
  localparam int ROWS             = 4;
  localparam int LVL_W            = 2;
  localparam int PH_W             = 3;
  localparam int TAB_W            = 27;

  localparam logic [1:0] MAX_MUX = 2'(NUM_COMMONS - 1);

  // Columns of a waveform table row: commons 0..3, then on and off levels.
  localparam logic [2:0] COL_ON  = 3'd4;
  localparam logic [2:0] COL_OFF = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LCD_ENABLE      = 2'd0,
    REG_MUX_SELECT      = 2'd1,
    REG_WAVEFORM_TYPE_B = 2'd2,
    REG_SEGMENT_ENABLE  = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic running;
    logic start;
    logic drive;
    logic stop;
    logic write;
    logic load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic lcd_enable;
    logic frame_end;
  } status_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] row;
    logic [1:0] lane;
  } idx_dec_t;

  // One octal digit per phase, phase 0 in the most significant used digit.
  localparam logic [TAB_W-1:0] WAVE_TAB [2][4][6] = '{
    '{
      '{27'o003,       27'o0,         27'o0,         27'o0,
        27'o030,       27'o003},
      '{27'o00321,     27'o02103,     27'o0,         27'o0,
        27'o03030,     27'o01212},
      '{27'o0032121,   27'o0210321,   27'o0212103,   27'o0,
        27'o0303030,   27'o0121212},
      '{27'o003212121, 27'o021032121, 27'o021210321, 27'o021212103,
        27'o030303030, 27'o012121212}
    },
    '{
      '{27'o003,       27'o0,         27'o0,         27'o0,
        27'o030,       27'o003},
      '{27'o00231,     27'o02013,     27'o0,         27'o0,
        27'o03300,     27'o01122},
      '{27'o0022311,   27'o0202131,   27'o0220113,   27'o0,
        27'o0333000,   27'o0111222},
      '{27'o002223111, 27'o020221311, 27'o022021131, 27'o022201113,
        27'o033330000, 27'o011112222}
    }
  };

  function automatic logic [LVL_W-1:0] wave_level(input logic       type_b,
                                                   input logic [1:0] mux,
                                                   input logic [2:0] col,
                                                   input logic [4:0] shift);
    logic [TAB_W-1:0] word;
    word = WAVE_TAB[type_b][mux][col];
    return LVL_W'(word >> shift);
  endfunction

  // Data register number to row (common) and byte lane.
  function automatic idx_dec_t decode_index(input logic [IDX_W-1:0] idx);
    idx_dec_t d;
    d.hit = 1'b1;
    unique case (idx)
      4'd0:    begin d.row = 2'd0; d.lane = 2'd0; end
      4'd1:    begin d.row = 2'd0; d.lane = 2'd1; end
      4'd2:    begin d.row = 2'd0; d.lane = 2'd2; end
      4'd3:    begin d.row = 2'd1; d.lane = 2'd0; end
      4'd4:    begin d.row = 2'd1; d.lane = 2'd1; end
      4'd5:    begin d.row = 2'd1; d.lane = 2'd2; end
      4'd6:    begin d.row = 2'd2; d.lane = 2'd0; end
      4'd7:    begin d.row = 2'd2; d.lane = 2'd1; end
      4'd8:    begin d.row = 2'd2; d.lane = 2'd2; end
      4'd9:    begin d.row = 2'd3; d.lane = 2'd0; end
      4'd10:   begin d.row = 2'd3; d.lane = 2'd1; end
      4'd11:   begin d.row = 2'd3; d.lane = 2'd2; end
      default: begin d.hit = 1'b0; d.row = 2'd0; d.lane = 2'd0; end
    endcase
    return d;
  endfunction

endpackage

// File: design/lcd_mwd_ctrl.sv
// ----------------------------------------------------------------------------
// LCD multiplex waveform driver controller
// Run/stop state machine, item handshake and result valid register.
// ----------------------------------------------------------------------------
module lcd_mwd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_op,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  lcd_mwd_pkg::status_t  status,
  output lcd_mwd_pkg::cmd_t     cmd
);

  typedef enum logic {
    ST_STOPPED,
    ST_RUNNING
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept, tick;

  // The result register frees up in the same cycle that its transfer completes.
  assign in_stall  = out_valid_r & out_stall;
  assign out_valid = out_valid_r;
  assign accept    = in_valid & ~in_stall;
  assign tick      = accept & (in_op == lcd_mwd_pkg::OP_TICK);

  always_comb begin
    cmd.running = (state_r == ST_RUNNING);
    cmd.start   = tick & (state_r == ST_STOPPED) & status.lcd_enable;
    cmd.drive   = tick & ((state_r == ST_RUNNING) | status.lcd_enable);
    cmd.stop    = cmd.drive & status.frame_end & ~status.lcd_enable;
    cmd.write   = accept & (in_op == lcd_mwd_pkg::OP_WRITE);
    cmd.load    = accept;

    state_nxt = state_r;
    unique case (state_r)
      ST_STOPPED: begin
        if (cmd.start) state_nxt = ST_RUNNING;
      end
      ST_RUNNING: begin
        if (cmd.stop) state_nxt = ST_STOPPED;
      end
      default: state_nxt = ST_STOPPED;
    endcase

    out_valid_nxt = out_valid_r;
    if (accept) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_STOPPED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: design/lcd_mwd_datapath.sv
// ----------------------------------------------------------------------------
// LCD multiplex waveform driver datapath
// Configuration registers, data and hold stores, phase logic and result register.
// ----------------------------------------------------------------------------
module lcd_mwd_datapath #(
  parameter int NUM_SEGMENTS = lcd_mwd_pkg::NUM_SEGMENTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lcd_mwd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lcd_mwd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [lcd_mwd_pkg::IDX_W-1:0]         in_data_index,
  input  logic [lcd_mwd_pkg::VAL_W-1:0]         in_data_value,
  input  lcd_mwd_pkg::cmd_t                     cmd,
  output lcd_mwd_pkg::status_t                  status,
  output logic [lcd_mwd_pkg::LVL_W-1:0]         out_com0_level,
  output logic [lcd_mwd_pkg::LVL_W-1:0]         out_com1_level,
  output logic [lcd_mwd_pkg::LVL_W-1:0]         out_com2_level,
  output logic [lcd_mwd_pkg::LVL_W-1:0]         out_com3_level,
  output logic [lcd_mwd_pkg::LVL_W-1:0]         out_on_level,
  output logic [lcd_mwd_pkg::LVL_W-1:0]         out_off_level,
  output logic [lcd_mwd_pkg::SEG_W-1:0]         out_seg_on,
  output logic [lcd_mwd_pkg::PH_W-1:0]          out_phase_now,
  output logic                                  out_frame_irq,
  output logic                                  out_write_error,
  output logic                                  out_drive_valid
);

  localparam int LW = lcd_mwd_pkg::LVL_W;

  // Configuration registers.
  logic                    lcd_enable_r;
  logic [1:0]              mux_select_r;
  logic                    type_b_r;
  logic [NUM_SEGMENTS-1:0] seg_en_r;

  // Running state.
  logic [lcd_mwd_pkg::PH_W-1:0] phase_r, phase_nxt;
  logic                         window_r, window_nxt;
  logic [1:0]                   act_mux_r, act_mux_nxt;
  logic                         act_b_r, act_b_nxt;
  logic [NUM_SEGMENTS-1:0]      data_r [lcd_mwd_pkg::ROWS];
  logic [NUM_SEGMENTS-1:0]      data_nxt [lcd_mwd_pkg::ROWS];
  logic [NUM_SEGMENTS-1:0]      hold_r [lcd_mwd_pkg::ROWS];
  logic [NUM_SEGMENTS-1:0]      hold_nxt [lcd_mwd_pkg::ROWS];

  // Result register.
  logic [LW-1:0]                com_r [lcd_mwd_pkg::NUM_COMMONS];
  logic [LW-1:0]                on_r, off_r;
  logic [lcd_mwd_pkg::SEG_W-1:0] seg_r;
  logic [lcd_mwd_pkg::PH_W-1:0] ph_out_r;
  logic                         irq_r, err_r, drv_r;

  // Phase logic.
  logic [1:0]              mux_clamp, eff_mux;
  logic                    eff_b;
  logic [2:0]              mux1;
  logic [3:0]              np, rem;
  logic [4:0]              shift;
  logic [2:0]              ph_raw, ph, sub3;
  logic [1:0]              sub;
  logic                    mid, frame_end;
  logic [NUM_SEGMENTS-1:0] row_sel;
  logic [LW-1:0]           com_lvl [lcd_mwd_pkg::NUM_COMMONS];
  logic [LW-1:0]           on_lvl, off_lvl;
  lcd_mwd_pkg::idx_dec_t   dec;
  logic                    write_ok, write_err;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcd_enable_r <= 1'b0;
      mux_select_r <= 2'd0;
      type_b_r     <= 1'b0;
      seg_en_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (lcd_mwd_pkg::cfg_reg_t'(cfg_index))
        lcd_mwd_pkg::REG_LCD_ENABLE:      lcd_enable_r <= cfg_data[0];
        lcd_mwd_pkg::REG_MUX_SELECT:      mux_select_r <= cfg_data[1:0];
        lcd_mwd_pkg::REG_WAVEFORM_TYPE_B: type_b_r     <= cfg_data[0];
        lcd_mwd_pkg::REG_SEGMENT_ENABLE:  seg_en_r     <= cfg_data[NUM_SEGMENTS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mux_clamp = (mux_select_r > lcd_mwd_pkg::MAX_MUX) ? lcd_mwd_pkg::MAX_MUX : mux_select_r;
    eff_mux   = cmd.start ? mux_clamp : act_mux_r;
    eff_b     = cmd.start ? type_b_r : act_b_r;
    mux1      = {1'b0, eff_mux} + 3'd1;
    np        = {mux1, 1'b0};
    ph_raw    = cmd.start ? '0 : phase_r;
    ph        = ({1'b0, ph_raw} >= np) ? '0 : ph_raw;
    rem       = np - 4'd1 - {1'b0, ph};
    shift     = {1'b0, rem} + {rem, 1'b0};
    sub3      = eff_b ? ((ph >= mux1) ? (ph - mux1) : ph) : (ph >> 1);
    sub       = sub3[1:0];
    mid       = eff_b && (ph == mux1);
    frame_end = (({1'b0, ph} + 4'd1) == np);

    for (int c = 0; c < lcd_mwd_pkg::NUM_COMMONS; c++) begin
      com_lvl[c] = (2'(c) <= eff_mux) ? lcd_mwd_pkg::wave_level(eff_b, eff_mux, 3'(c), shift)
                                      : '0;
    end
    on_lvl  = lcd_mwd_pkg::wave_level(eff_b, eff_mux, lcd_mwd_pkg::COL_ON, shift);
    off_lvl = lcd_mwd_pkg::wave_level(eff_b, eff_mux, lcd_mwd_pkg::COL_OFF, shift);
    // At start the hold store is refreshed in this same tick, so read the data store.
    row_sel = cmd.start ? data_r[sub] : hold_r[sub];

    dec       = lcd_mwd_pkg::decode_index(in_data_index);
    write_ok  = (!lcd_enable_r && !cmd.running) || window_r || (act_mux_r == 2'd0);
    write_err = cmd.write && dec.hit && !write_ok;

    phase_nxt   = phase_r;
    window_nxt  = window_r;
    act_mux_nxt = act_mux_r;
    act_b_nxt   = act_b_r;
    data_nxt    = data_r;
    hold_nxt    = hold_r;

    if (cmd.start) begin
      act_mux_nxt = mux_clamp;
      act_b_nxt   = type_b_r;
      if (!type_b_r) window_nxt = 1'b1;
    end
    if (cmd.drive) begin
      if (mid) window_nxt = 1'b1;
      phase_nxt = frame_end ? '0 : ph + 3'd1;
      if (frame_end || cmd.start) hold_nxt = data_r;
      if (frame_end && eff_b) window_nxt = 1'b0;
    end
    if (cmd.stop) window_nxt = 1'b1;

    if (cmd.write && dec.hit && write_ok) begin
      for (int j = 0; j < NUM_SEGMENTS; j++) begin
        if (2'(j / 8) == dec.lane) data_nxt[dec.row][j] = in_data_value[j % 8];
      end
    end
  end

  assign status.lcd_enable = lcd_enable_r;
  assign status.frame_end  = frame_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      window_r  <= 1'b1;
      act_mux_r <= 2'd0;
      act_b_r   <= 1'b0;
      for (int r = 0; r < lcd_mwd_pkg::ROWS; r++) begin
        data_r[r] <= '0;
        hold_r[r] <= '0;
      end
    end else begin
      phase_r   <= phase_nxt;
      window_r  <= window_nxt;
      act_mux_r <= act_mux_nxt;
      act_b_r   <= act_b_nxt;
      data_r    <= data_nxt;
      hold_r    <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int c = 0; c < lcd_mwd_pkg::NUM_COMMONS; c++) begin
        com_r[c] <= cmd.drive ? com_lvl[c] : '0;
      end
      on_r     <= cmd.drive ? on_lvl : '0;
      off_r    <= cmd.drive ? off_lvl : '0;
      seg_r    <= cmd.drive ? lcd_mwd_pkg::SEG_W'(row_sel & seg_en_r) : '0;
      ph_out_r <= cmd.drive ? ph : '0;
      irq_r    <= cmd.drive && (mid || cmd.stop);
      err_r    <= write_err;
      drv_r    <= cmd.drive;
    end
  end

  assign out_com0_level  = com_r[0];
  assign out_com1_level  = com_r[1];
  assign out_com2_level  = com_r[2];
  assign out_com3_level  = com_r[3];
  assign out_on_level    = on_r;
  assign out_off_level   = off_r;
  assign out_seg_on      = seg_r;
  assign out_phase_now   = ph_out_r;
  assign out_frame_irq   = irq_r;
  assign out_write_error = err_r;
  assign out_drive_valid = drv_r;

endmodule

// File: design/lcd_multiplex_waveform_driver_unit.sv
// ----------------------------------------------------------------------------
// LCD multiplex waveform driver unit
// Segment LCD phase and level generator with double-buffered segment data.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the in_ channel: a tick (in_op clear) drives one
// phase of a frame of 2*(mux+1) phases if enabled or running; a write
// (in_op set) loads one byte of the twelve data registers. Every item gives
// exactly one result on the out_ channel, carrying the bias level index of
// each common, the on and off levels, the set of enabled segments at the on
// level and the interrupt and write error flags. Items are accepted where
// valid is high and stall low. The configuration registers are written over
// the cfg_ channel, which is always ready; they are to be written only while
// the unit has no transfer outstanding.
// Timing: a result is registered in the cycle after its item is accepted,
// and one item is taken every cycle unless in_stall holds it. The result
// register is the only buffering: while it holds a result that the receiver
// stalls, in_stall is raised and the next item waits; when that transfer
// completes, a new item is accepted in the same cycle.
// Reset (rst_n low, synchronous) stops the display, opens the write window,
// clears the data and hold stores and the configuration, and empties the
// result register.
// ----------------------------------------------------------------------------
module lcd_multiplex_waveform_driver_unit #(
  parameter int NUM_SEGMENTS = lcd_mwd_pkg::NUM_SEGMENTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lcd_mwd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lcd_mwd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_op,
  input  logic [lcd_mwd_pkg::IDX_W-1:0]         in_data_index,
  input  logic [lcd_mwd_pkg::VAL_W-1:0]         in_data_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [lcd_mwd_pkg::LVL_W-1:0]         out_com0_level,
  output logic [lcd_mwd_pkg::LVL_W-1:0]         out_com1_level,
  output logic [lcd_mwd_pkg::LVL_W-1:0]         out_com2_level,
  output logic [lcd_mwd_pkg::LVL_W-1:0]         out_com3_level,
  output logic [lcd_mwd_pkg::LVL_W-1:0]         out_on_level,
  output logic [lcd_mwd_pkg::LVL_W-1:0]         out_off_level,
  output logic [lcd_mwd_pkg::SEG_W-1:0]         out_seg_on,
  output logic [lcd_mwd_pkg::PH_W-1:0]          out_phase_now,
  output logic                                  out_frame_irq,
  output logic                                  out_write_error,
  output logic                                  out_drive_valid
);

  // The controller owns the run/stop state and the handshake; the datapath
  // owns every register that holds data, phase and the write window.
  lcd_mwd_pkg::cmd_t    cmd;
  lcd_mwd_pkg::status_t status;

  lcd_mwd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  lcd_mwd_datapath #(
    .NUM_SEGMENTS (NUM_SEGMENTS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_data_index   (in_data_index),
    .in_data_value   (in_data_value),
    .cmd             (cmd),
    .status          (status),
    .out_com0_level  (out_com0_level),
    .out_com1_level  (out_com1_level),
    .out_com2_level  (out_com2_level),
    .out_com3_level  (out_com3_level),
    .out_on_level    (out_on_level),
    .out_off_level   (out_off_level),
    .out_seg_on      (out_seg_on),
    .out_phase_now   (out_phase_now),
    .out_frame_irq   (out_frame_irq),
    .out_write_error (out_write_error),
    .out_drive_valid (out_drive_valid)
  );

endmodule

// File: design/lcd_mwd_checker.sv
// ----------------------------------------------------------------------------
// LCD multiplex waveform driver checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module lcd_mwd_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [lcd_mwd_pkg::LVL_W-1:0]     out_com0_level,
  input logic [lcd_mwd_pkg::LVL_W-1:0]     out_on_level,
  input logic [lcd_mwd_pkg::SEG_W-1:0]     out_seg_on,
  input logic [lcd_mwd_pkg::PH_W-1:0]      out_phase_now,
  input logic                              out_frame_irq,
  input logic                              out_write_error,
  input logic                              out_drive_valid
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result withdrawn while stalled");

  // Every accepted item leaves a result in the next cycle.
  a_item_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted item gave no result");

  // A result that did not drive the display carries no levels or segments.
  a_quiet_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_drive_valid) |->
      (out_com0_level == '0 && out_on_level == '0 && out_seg_on == '0 &&
       out_phase_now == '0 && !out_frame_irq))
    else $error("non-driving result carries display data");

  // A rejected write never comes from a tick.
  a_error_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_write_error) |-> !out_drive_valid)
    else $error("write error on a driving result");

endmodule

bind lcd_multiplex_waveform_driver_unit lcd_mwd_checker u_lcd_mwd_checker (.*);
